FILE: design/jacobi_eigen_3x3_top_assert.svh
// assertion helpers used by the eigen solver top level
`ifndef JACOBI_EIGEN_3X3_TOP_ASSERT_SVH
`define JACOBI_EIGEN_3X3_TOP_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define JEIG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk outside reset
`define JEIG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/jeig_pkg.sv
`timescale 1ns / 1ps
package jeig_pkg;

  localparam int DW = 32;
  localparam int CB = 30;
  localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  // busy / done status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // magnitude of a signed word, most negative value included
  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
    mag = x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  // saturate a one-bit-wider signed value
  function automatic logic signed [DW-1:0] sat1(input logic signed [DW:0] x);
    if (x[DW] != x[DW-1]) begin
      sat1 = x[DW] ? DMIN : DMAX;
    end else begin
      sat1 = x[DW-1:0];
    end
  endfunction

  // sign and magnitude to a saturated word
  function automatic logic signed [DW-1:0] from_sm(input logic neg, input logic [DW:0] m);
    if (!neg) begin
      from_sm = (m > {1'b0, DMAX}) ? DMAX : m[DW-1:0];
    end else if (m > {1'b0, DMAX}) begin
      from_sm = DMIN;
    end else begin
      from_sm = ~m[DW-1:0] + 1'b1;
    end
  endfunction

  // saturating add of two sign-magnitude terms
  function automatic logic signed [DW-1:0] combine(input logic n1, input logic [DW-1:0] m1,
                                                  input logic n2, input logic [DW-1:0] m2);
    if (n1 == n2) begin
      combine = from_sm(n1, {1'b0, m1} + {1'b0, m2});
    end else if (m1 >= m2) begin
      combine = from_sm(n1, {1'b0, m1 - m2});
    end else begin
      combine = from_sm(n2, {1'b0, m2 - m1});
    end
  endfunction

  // |a - b| without overflow
  function automatic logic [DW:0] abs_delta(input logic signed [DW-1:0] a,
                                            input logic signed [DW-1:0] b);
    logic signed [DW:0] d;
    d = {a[DW-1], a} - {b[DW-1], b};
    abs_delta = d[DW] ? (~d + 1'b1) : d;
  endfunction

endpackage

FILE: design/jeig_mul.sv
`timescale 1ns / 1ps
module jeig_mul (
  input  logic                          clk,
  input  logic [jeig_pkg::DW-1:0]       a,
  input  logic [jeig_pkg::DW-1:0]       b,
  output logic [2*jeig_pkg::DW-1:0]     p
);
  import jeig_pkg::*;

  // registered unsigned product
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: design/jeig_div.sv
`timescale 1ns / 1ps
module jeig_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [2*jeig_pkg::DW-1:0]     n,
  input  logic [jeig_pkg::DW-1:0]       d,
  output logic [jeig_pkg::DW-1:0]       q,
  output jeig_pkg::unit_stat_t          stat
);
  import jeig_pkg::*;

  localparam int NW = 2 * DW;
  localparam int CW = $clog2(NW);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [NW-1:0] nq;
  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [DW:0]   r2;
  logic          take;

  // one quotient bit per cycle, restoring
  assign r2   = {rem, nq[NW-1]};
  assign take = (r2 >= {1'b0, dreg});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq   <= n;
      rem  <= '0;
      dreg <= d;
      cnt  <= '0;
    end else if (busy) begin
      rem <= take ? DW'(r2 - {1'b0, dreg}) : r2[DW-1:0];
      nq  <= {nq[NW-2:0], take};
      cnt <= cnt + 1'b1;
    end
  end

  assign q         = nq[DW-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: design/jeig_sqrt.sv
`timescale 1ns / 1ps
module jeig_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [2*jeig_pkg::DW-1:0]     x,
  output logic [jeig_pkg::DW-1:0]       root,
  output jeig_pkg::unit_stat_t          stat
);
  import jeig_pkg::*;

  localparam int XW = 2 * DW;
  localparam int CW = $clog2(DW);
  localparam int RW = DW + 4;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [XW-1:0] xs;
  logic [RW-1:0] rem;
  logic [RW-1:0] r4;
  logic [RW-1:0] trial;
  logic          take;

  // two radicand bits per cycle, one root bit out
  assign r4    = {rem[RW-3:0], xs[XW-1:XW-2]};
  assign trial = {2'b00, root, 2'b01};
  assign take  = (r4 >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(DW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rem  <= take ? (r4 - trial) : r4;
      root <= {root[DW-2:0], take};
      xs   <= {xs[XW-3:0], 2'b00};
      cnt  <= cnt + 1'b1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: design/jacobi_eigen_3x3_top.sv
`timescale 1ns / 1ps
// Eigenvalues of a symmetric 3x3 Q16.16 matrix by classical Jacobi rotations. One
// request is taken at a time: in_ready is high only while the solver is idle and out of
// reset, and the result sits in an output register until taken. Each rotation uses two
// divides (pivot ratio, then the cosine term), three square roots (radius, cosine, sine),
// six passes through the shared multiplier, plus the pivot, set-up, write-back and
// stop-test states. The ratio divide is skipped when the pair is balanced. At most
// max_iterations rotations are made per request.
// Registers: tolerance at 0x0, max_iterations at 0x4.
`include "jacobi_eigen_3x3_top_assert.svh"
module jacobi_eigen_3x3_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [jeig_pkg::DW-1:0]    m00,
  input  logic signed [jeig_pkg::DW-1:0]    m01,
  input  logic signed [jeig_pkg::DW-1:0]    m02,
  input  logic signed [jeig_pkg::DW-1:0]    m11,
  input  logic signed [jeig_pkg::DW-1:0]    m12,
  input  logic signed [jeig_pkg::DW-1:0]    m22,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [jeig_pkg::DW-1:0]    eig0,
  output logic signed [jeig_pkg::DW-1:0]    eig1,
  output logic signed [jeig_pkg::DW-1:0]    eig2,
  output logic [7:0]                        rotations,
  output logic                              converged
);
  import jeig_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PIVOT = 5'd1;
  localparam logic [4:0] S_PREP  = 5'd2;
  localparam logic [4:0] S_DIVT  = 5'd3;
  localparam logic [4:0] S_TT    = 5'd4;
  localparam logic [4:0] S_TTW   = 5'd5;
  localparam logic [4:0] S_RR    = 5'd6;
  localparam logic [4:0] S_HALF  = 5'd7;
  localparam logic [4:0] S_HALFW = 5'd8;
  localparam logic [4:0] S_DIVW  = 5'd9;
  localparam logic [4:0] S_CS    = 5'd10;
  localparam logic [4:0] S_CW    = 5'd11;
  localparam logic [4:0] S_SW    = 5'd12;
  localparam logic [4:0] S_M1    = 5'd13;
  localparam logic [4:0] S_M2    = 5'd14;
  localparam logic [4:0] S_M3    = 5'd15;
  localparam logic [4:0] S_M4    = 5'd16;
  localparam logic [4:0] S_M5    = 5'd17;
  localparam logic [4:0] S_WB    = 5'd18;
  localparam logic [4:0] S_CONV  = 5'd19;
  localparam logic [4:0] S_FIN   = 5'd20;

  localparam logic [1:0] PAIR01 = 2'd0;
  localparam logic [1:0] PAIR02 = 2'd1;
  localparam logic [1:0] PAIR12 = 2'd2;

  localparam logic       REG_TOL   = 1'b0;
  localparam logic       REG_MAXIT = 1'b1;

  localparam logic [2*DW-1:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [DW-1:0]   ONE_Q30 = 32'h4000_0000;

  logic [4:0]             state;
  logic [15:0]            tolerance;
  logic [7:0]             max_it;
  logic signed [DW-1:0]   mat [6];
  logic [7:0]             cnt;
  logic                   conv;
  logic [1:0]             k;
  logic signed [DW-1:0]   app, aqq, apq, arp, arq;
  logic [DW-1:0]          bm;
  logic                   ubig, sneg, s2neg;
  logic signed [DW-1:0]   mean;
  logic [DW-2:0]          t, rr, w, c, s;
  logic [DW-1:0]          half;
  logic [DW-1:0]          p1, p2, p3, p4;
  logic signed [DW-1:0]   old_p, old_q;

  logic                   div_start, sq_start;
  logic [2*DW-1:0]        div_n, sq_x, mul_p;
  logic [DW-1:0]          div_d, div_q, sq_root, mul_a, mul_b;
  unit_stat_t             div_stat, sq_stat;

  // shared arithmetic units
  jeig_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  jeig_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .n(div_n), .d(div_d),
    .q(div_q), .stat(div_stat)
  );

  jeig_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x(sq_x),
    .root(sq_root), .stat(sq_stat)
  );

  // configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAXIT) ? {24'b0, max_it} : {16'b0, tolerance};

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= 16'd1;
      max_it    <= 8'd64;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_TOL) begin
        tolerance <= pwdata[15:0];
      end else begin
        max_it <= pwdata[7:0];
      end
    end
  end

  assign in_ready = (state == S_IDLE) && !rst;

  // pivot search: first strictly larger off-diagonal magnitude wins
  logic [DW-1:0] a1, a2, a4, piv_m;
  logic [1:0]    piv_k;
  logic          piv_found;
  always_comb begin
    a1        = mag(mat[1]);
    a2        = mag(mat[2]);
    a4        = mag(mat[4]);
    piv_m     = '0;
    piv_k     = PAIR01;
    piv_found = 1'b0;
    if (a1 > piv_m) begin
      piv_m = a1; piv_k = PAIR01; piv_found = 1'b1;
    end
    if (a2 > piv_m) begin
      piv_m = a2; piv_k = PAIR02; piv_found = 1'b1;
    end
    if (a4 > piv_m) begin
      piv_k = PAIR12; piv_found = 1'b1;
    end
  end

  // rotation set-up from the latched pair
  logic signed [DW-1:0] p_diff;
  logic [DW-1:0]        p_u, p_v, p_bm, p_sm;
  logic [DW:0]          p_two;
  logic signed [DW:0]   p_sum;
  always_comb begin
    p_diff = sat1({app[DW-1], app} - {aqq[DW-1], aqq});
    p_u    = mag(p_diff);
    p_two  = {mag(apq), 1'b0};
    if (p_two > {1'b0, DMAX}) begin
      p_v = apq[DW-1] ? DMIN : DMAX;
    end else begin
      p_v = p_two[DW-1:0];
    end
    p_bm  = (p_u >= p_v) ? p_u : p_v;
    p_sm  = (p_u >= p_v) ? p_v : p_u;
    p_sum = {app[DW-1], app} + {aqq[DW-1], aqq};
  end

  // new values of the rotated entries
  logic signed [DW-1:0] n_pp, n_qq, n_rp, n_rq;
  always_comb begin
    n_pp = combine(mean[DW-1], mag(mean), s2neg, half);
    n_qq = combine(mean[DW-1], mag(mean), !s2neg, half);
    n_rp = combine(arp[DW-1], p1, arq[DW-1] ^ sneg, p2);
    n_rq = combine(!(arp[DW-1] ^ sneg), p3, arq[DW-1], p4);
  end

  // diagonal change test after a rotation
  logic signed [DW-1:0] cur_p, cur_q;
  logic                 tol_met;
  always_comb begin
    unique case (k)
      PAIR01:  begin cur_p = mat[0]; cur_q = mat[3]; end
      PAIR02:  begin cur_p = mat[0]; cur_q = mat[5]; end
      default: begin cur_p = mat[3]; cur_q = mat[5]; end
    endcase
    tol_met = (tolerance != 16'd0) &&
              (abs_delta(cur_p, old_p) < {17'b0, tolerance}) &&
              (abs_delta(cur_q, old_q) < {17'b0, tolerance});
  end

  // unit operand steering
  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    sq_start  = 1'b0;
    sq_x      = '0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_PREP: begin
        div_start = (p_sm != p_bm);
        div_n     = {2'b00, p_sm, 30'b0};
        div_d     = p_bm;
      end
      S_TT: begin
        mul_a = {1'b0, t};
        mul_b = {1'b0, t};
      end
      S_TTW: begin
        sq_start = 1'b1;
        sq_x     = ONE_Q60 + mul_p;
      end
      S_HALF: begin
        mul_a = bm;
        mul_b = {1'b0, rr};
      end
      S_HALFW: begin
        div_start = 1'b1;
        div_n     = ubig ? ONE_Q60 : {3'b000, t, 30'b0};
        div_d     = {1'b0, rr};
      end
      S_CS: begin
        sq_start = 1'b1;
        sq_x     = {3'b000, ONE_Q30 + {1'b0, w}, 29'b0};
      end
      S_CW: begin
        sq_start = sq_stat.done;
        sq_x     = {3'b000, ONE_Q30 - {1'b0, w}, 29'b0};
      end
      S_M1: begin
        mul_a = mag(arp);
        mul_b = {1'b0, c};
      end
      S_M2: begin
        mul_a = mag(arq);
        mul_b = {1'b0, s};
      end
      S_M3: begin
        mul_a = mag(arp);
        mul_b = {1'b0, s};
      end
      S_M4: begin
        mul_a = mag(arq);
        mul_b = {1'b0, c};
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      conv  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cnt   <= '0;
            state <= S_PIVOT;
          end
        end
        S_PIVOT: begin
          if (!piv_found) begin
            conv  <= 1'b1;
            state <= S_FIN;
          end else if (cnt >= max_it) begin
            conv  <= 1'b0;
            state <= S_FIN;
          end else begin
            state <= S_PREP;
          end
        end
        S_PREP:  state <= (p_sm == p_bm) ? S_TT : S_DIVT;
        S_DIVT:  if (div_stat.done) state <= S_TT;
        S_TT:    state <= S_TTW;
        S_TTW:   state <= S_RR;
        S_RR:    if (sq_stat.done) state <= S_HALF;
        S_HALF:  state <= S_HALFW;
        S_HALFW: state <= S_DIVW;
        S_DIVW:  if (div_stat.done) state <= S_CS;
        S_CS:    state <= S_CW;
        S_CW:    if (sq_stat.done) state <= S_SW;
        S_SW:    if (sq_stat.done) state <= S_M1;
        S_M1:    state <= S_M2;
        S_M2:    state <= S_M3;
        S_M3:    state <= S_M4;
        S_M4:    state <= S_M5;
        S_M5:    state <= S_WB;
        S_WB: begin
          cnt   <= cnt + 8'd1;
          state <= S_CONV;
        end
        S_CONV: begin
          if (tol_met) begin
            conv  <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_PIVOT;
          end
        end
        S_FIN:   if (!out_valid || out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          mat[0] <= m00; mat[1] <= m01; mat[2] <= m02;
          mat[3] <= m11; mat[4] <= m12; mat[5] <= m22;
        end
      end
      S_PIVOT: begin
        k <= piv_k;
        unique case (piv_k)
          PAIR01: begin
            app <= mat[0]; aqq <= mat[3]; apq <= mat[1]; arp <= mat[2]; arq <= mat[4];
          end
          PAIR02: begin
            app <= mat[0]; aqq <= mat[5]; apq <= mat[2]; arp <= mat[1]; arq <= mat[4];
          end
          default: begin
            app <= mat[3]; aqq <= mat[5]; apq <= mat[4]; arp <= mat[1]; arq <= mat[2];
          end
        endcase
      end
      S_PREP: begin
        bm    <= p_bm;
        ubig  <= (p_u >= p_v);
        sneg  <= (p_diff != '0) && (apq[DW-1] != p_diff[DW-1]);
        s2neg <= (p_diff != '0) ? p_diff[DW-1] : apq[DW-1];
        mean  <= p_sum[DW:1];
        if (p_sm == p_bm) begin
          t <= ONE_Q30[DW-2:0];
        end
      end
      S_DIVT:  if (div_stat.done) t <= div_q[DW-2:0];
      S_RR:    if (sq_stat.done) rr <= sq_root[DW-2:0];
      S_HALFW: half <= mul_p[2*DW-2:DW-1];
      S_DIVW:  if (div_stat.done) w <= div_q[DW-2:0];
      S_CW:    if (sq_stat.done) c <= sq_root[DW-2:0];
      S_SW:    if (sq_stat.done) s <= sq_root[DW-2:0];
      S_M2:    p1 <= mul_p[DW+CB-1:CB];
      S_M3:    p2 <= mul_p[DW+CB-1:CB];
      S_M4:    p3 <= mul_p[DW+CB-1:CB];
      S_M5:    p4 <= mul_p[DW+CB-1:CB];
      S_WB: begin
        old_p <= app;
        old_q <= aqq;
        unique case (k)
          PAIR01: begin
            mat[0] <= n_pp; mat[3] <= n_qq; mat[1] <= '0; mat[2] <= n_rp; mat[4] <= n_rq;
          end
          PAIR02: begin
            mat[0] <= n_pp; mat[5] <= n_qq; mat[2] <= '0; mat[1] <= n_rp; mat[4] <= n_rq;
          end
          default: begin
            mat[3] <= n_pp; mat[5] <= n_qq; mat[4] <= '0; mat[1] <= n_rp; mat[2] <= n_rq;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || out_ready)) begin
      eig0      <= mat[0];
      eig1      <= mat[3];
      eig2      <= mat[5];
      rotations <= cnt;
      converged <= conv;
    end
  end

  // unit start only when idle, rotation bookkeeping
  `JEIG_ASSERT_SAME(a_div_free, div_start, !div_stat.busy, "divider started while busy")
  `JEIG_ASSERT_SAME(a_sqrt_free, sq_start, !sq_stat.busy, "square root started while busy")
  `JEIG_ASSERT_NEXT(a_rot_count, state == S_WB, cnt == $past(cnt) + 8'd1, "rotation count slip")
  `JEIG_ASSERT_NEXT(a_pivot_zero, state == S_WB, (k == PAIR01 && mat[1] == '0) || (k == PAIR02 && mat[2] == '0) || (k == PAIR12 && mat[4] == '0), "pivot entry not cleared")

endmodule

FILE: verif/jeig_checker.sv
`timescale 1ns / 1ps
module jeig_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           pready,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [jeig_pkg::DW-1:0] m00,
  input  logic signed [jeig_pkg::DW-1:0] m01,
  input  logic signed [jeig_pkg::DW-1:0] m02,
  input  logic signed [jeig_pkg::DW-1:0] m11,
  input  logic signed [jeig_pkg::DW-1:0] m12,
  input  logic signed [jeig_pkg::DW-1:0] m22,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [jeig_pkg::DW-1:0] eig0,
  input  logic signed [jeig_pkg::DW-1:0] eig1,
  input  logic signed [jeig_pkg::DW-1:0] eig2,
  input  logic [7:0]                     rotations,
  input  logic                           converged,
  output int                             errors,
  output int                             pending,
  output int                             results_seen
);
  import jeig_pkg::*;

  localparam logic [2:0] ADDR_TOL = 3'h0;
  localparam logic [2:0] ADDR_MAXIT = 3'h4;
  localparam longint POS_LIM = 64'sd2147483647;
  localparam int Q = 30;

  typedef struct {
    logic [DW-1:0] e0;
    logic [DW-1:0] e1;
    logic [DW-1:0] e2;
    logic [7:0]    rot;
    logic          conv;
  } eig_res_t;

  eig_res_t expected_eigs[$];
  logic [15:0] tol_reg;
  logic [7:0]  maxit_reg;

  function automatic longint unsigned abs64(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  // sign and magnitude back to a saturated data word
  function automatic longint sat_word(bit neg, longint unsigned m);
    if (!neg) return m > POS_LIM ? POS_LIM : longint'(m);
    if (m > POS_LIM) return -POS_LIM - 1;
    return -longint'(m);
  endfunction

  function automatic longint add_sm(bit n1, longint unsigned m1, bit n2, longint unsigned m2);
    if (n1 == n2) return sat_word(n1, m1 + m2);
    if (m1 >= m2) return sat_word(n1, m1 - m2);
    return sat_word(n2, m2 - m1);
  endfunction

  // magnitude times a Q1.30 factor, truncated
  function automatic longint unsigned scale_q30(longint unsigned m, longint unsigned k);
    return (m >> Q) * k + (((m & ((64'd1 << Q) - 1)) * k) >> Q);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // full solve of one matrix: pivot search, rotation, stop tests
  function automatic eig_res_t solve_eigs(longint a0, longint a1, longint a2,
                                          longint a3, longint a4, longint a5);
    longint a [6];
    int off_k [3];
    int pd_k [3];
    int qd_k [3];
    int rp_k [3];
    int rq_k [3];
    int k, best, i;
    longint unsigned bestm, mm, u, v, bm, sm, t, rr, half, w, c, s, rem, ma;
    longint app, aqq, apq, arp, arq, diff, mean;
    longint old0, old1, old2;
    bit sneg, s2neg, conv;
    logic [7:0] cnt;
    eig_res_t res;
    a = '{a0, a1, a2, a3, a4, a5};
    off_k = '{1, 2, 4};
    pd_k = '{0, 0, 3};
    qd_k = '{3, 5, 5};
    rp_k = '{2, 1, 1};
    rq_k = '{4, 4, 2};
    conv = 0;
    cnt = 0;
    forever begin
      best = -1;
      bestm = 0;
      for (k = 0; k < 3; k++) begin
        mm = abs64(a[off_k[k]]);
        if (mm > bestm) begin
          bestm = mm;
          best = k;
        end
      end
      if (best < 0) begin
        conv = 1;
        break;
      end
      if (cnt >= maxit_reg) break;
      old0 = a[0];
      old1 = a[3];
      old2 = a[5];
      app = a[pd_k[best]];
      aqq = a[qd_k[best]];
      apq = a[off_k[best]];
      arp = a[rp_k[best]];
      arq = a[rq_k[best]];
      diff = add_sm(app < 0, abs64(app), !(aqq < 0), abs64(aqq));
      ma = abs64(apq);
      u = abs64(diff);
      v = abs64(sat_word(apq < 0, ma * 2));
      bm = u >= v ? u : v;
      sm = u >= v ? v : u;
      // pivot ratio by restoring division
      if (sm == bm) begin
        t = 64'd1 << Q;
      end else begin
        t = 0;
        rem = sm;
        for (i = 0; i < Q; i++) begin
          t = t << 1;
          if (rem >= bm - rem) begin
            rem = rem - (bm - rem);
            t = t | 1;
          end else begin
            rem = rem + rem;
          end
        end
      end
      rr = root64((64'd1 << (2 * Q)) + t * t);
      half = (bm >> (Q + 1)) * rr + (((bm & ((64'd1 << (Q + 1)) - 1)) * rr) >> (Q + 1));
      w = u >= v ? (64'd1 << (2 * Q)) / rr : (t << Q) / rr;
      c = root64(((64'd1 << Q) + w) << (Q - 1));
      s = root64(((64'd1 << Q) - w) << (Q - 1));
      sneg = diff != 0 && ((apq < 0) != (diff < 0));
      s2neg = diff != 0 ? diff < 0 : apq < 0;
      mean = (app >>> 1) + (aqq >>> 1) + (app & aqq & 64'sd1);
      a[pd_k[best]] = add_sm(mean < 0, abs64(mean), s2neg, half);
      a[qd_k[best]] = add_sm(mean < 0, abs64(mean), !s2neg, half);
      a[off_k[best]] = 0;
      a[rp_k[best]] = add_sm(arp < 0, scale_q30(abs64(arp), c),
                             (arq < 0) != sneg, scale_q30(abs64(arq), s));
      a[rq_k[best]] = add_sm((arp < 0) == sneg, scale_q30(abs64(arp), s),
                             arq < 0, scale_q30(abs64(arq), c));
      cnt++;
      if (abs64(a[0] - old0) < tol_reg && abs64(a[3] - old1) < tol_reg &&
          abs64(a[5] - old2) < tol_reg) begin
        conv = 1;
        break;
      end
    end
    res.e0 = a[0][DW-1:0];
    res.e1 = a[3][DW-1:0];
    res.e2 = a[5][DW-1:0];
    res.rot = cnt;
    res.conv = conv;
    return res;
  endfunction

  // register writes, requests in, results out
  always @(posedge clk) begin
    eig_res_t exp_r;
    if (rst) begin
      tol_reg <= 16'd1;
      maxit_reg <= 8'd64;
      errors <= 0;
      results_seen <= 0;
      expected_eigs.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_TOL) tol_reg <= pwdata[15:0];
        else if (paddr == ADDR_MAXIT) maxit_reg <= pwdata[7:0];
      end
      if (in_valid && in_ready)
        expected_eigs.push_back(solve_eigs(m00, m01, m02, m11, m12, m22));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_eigs.size() == 0) begin
          $display("%0t: result with no request pending: %h %h %h %0d %0d",
                   $time, eig0, eig1, eig2, rotations, converged);
          errors <= errors + 1;
        end else begin
          exp_r = expected_eigs.pop_front();
          if (exp_r.e0 !== eig0 || exp_r.e1 !== eig1 || exp_r.e2 !== eig2 ||
              exp_r.rot !== rotations || exp_r.conv !== converged) begin
            $display("%0t: mismatch exp eig %h %h %h rot %0d conv %0d", $time,
                     exp_r.e0, exp_r.e1, exp_r.e2, exp_r.rot, exp_r.conv);
            $display("%0t:          got eig %h %h %h rot %0d conv %0d", $time,
                     eig0, eig1, eig2, rotations, converged);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  assign pending = expected_eigs.size();

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import jeig_pkg::*;

  localparam logic [2:0] ADDR_TOL = 3'h0;
  localparam logic [2:0] ADDR_MAXIT = 3'h4;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic signed [DW-1:0] m00 = 0, m01 = 0, m02 = 0, m11 = 0, m12 = 0, m22 = 0;
  logic out_valid, out_ready = 0;
  logic signed [DW-1:0] eig0, eig1, eig2;
  logic [7:0] rotations;
  logic converged;
  int errors, pending, results_seen;
  int sent = 0;
  bit quiet = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_cnt = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  jacobi_eigen_3x3_top dut (.*);

  jeig_checker u_chk (.*);

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 32);
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= data; penable <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain_results();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_matrix(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                             logic [31:0] a3, logic [31:0] a4, logic [31:0] a5);
    if (!quiet && $urandom_range(0, 99) < 32) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    m00 <= a0; m01 <= a1; m02 <= a2; m11 <= a3; m12 <= a4; m22 <= a5;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // entry value: mostly moderate Q16.16, sometimes full range, extremes, 1.0 or (off-diagonal) zero
  function automatic logic [31:0] pick_entry(bit offdiag);
    int sel;
    sel = $urandom_range(0, 99);
    if (offdiag && sel < 12) return 32'h0;
    if (sel < 18) return $urandom;
    if (sel < 22) return 32'h7fffffff;
    if (sel < 26) return 32'h80000000;
    if (sel < 30) return 32'h00010000;
    return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff;
  endfunction

  task automatic random_matrices(int count);
    for (int i = 0; i < count; i++)
      send_matrix(pick_entry(0), pick_entry(1), pick_entry(1),
                  pick_entry(0), pick_entry(1), pick_entry(0));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed matrices with reset register values
    send_matrix(0, 0, 0, 0, 0, 0);
    send_matrix(32'h00010000, 0, 0, 32'hfffe0000, 0, 32'h00030000);
    send_matrix(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff);
    send_matrix(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000);
    send_matrix(32'h00020000, 32'h00010000, 0, 32'h00020000, 0, 32'h00050000);
    send_matrix(32'h00020000, 32'hffff0000, 0, 32'h00020000, 0, 32'h00050000);
    send_matrix(32'h00010000, 0, 32'h00008000, 32'h0, 0, 32'h00010000);
    send_matrix(0, 0, 0, 32'h00010000, 32'hffff8000, 32'h00010000);
    send_matrix(0, 32'h00010000, 32'h00010000, 0, 32'h00010000, 0);
    send_matrix(32'h00030000, 32'hffff0000, 32'h00010000, 32'h00030000, 32'hffff0000,
                32'h00030000);
    send_matrix(32'h7fffffff, 32'h00000001, 0, 32'h80000000, 0, 0);
    send_matrix(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h00000001,
                32'h80000000);
    send_matrix(32'h00000001, 32'h00000001, 32'hffffffff, 32'hffffffff, 32'h00000001, 0);
    send_matrix(32'h12345678, 32'hedcba987, 32'h0f0f0f0f, 32'hf0f0f0f0, 32'h55555555,
                32'haaaaaaaa);
    drain_results();

    // default registers, random with a quiet stretch and a long receiver hold-off
    random_matrices(60);
    quiet = 1;
    random_matrices(40);
    quiet = 0;
    hold_req = 1;
    random_matrices(60);
    drain_results();

    // zero tolerance never passes the change test, short limit
    reg_write(ADDR_TOL, 32'd0);
    reg_write(ADDR_MAXIT, 32'd6);
    send_matrix(32'h00010000, 32'h00010000, 0, 32'h00020000, 0, 32'h00030000);
    random_matrices(100);
    drain_results();

    // single rotation limit, moderate tolerance
    reg_write(ADDR_TOL, 32'd100);
    reg_write(ADDR_MAXIT, 32'd1);
    random_matrices(150);
    drain_results();

    // widest settings
    reg_write(ADDR_TOL, 32'd65535);
    reg_write(ADDR_MAXIT, 32'd255);
    random_matrices(40);
    drain_results();

    // mid settings
    reg_write(ADDR_TOL, 32'd16);
    reg_write(ADDR_MAXIT, 32'd20);
    random_matrices(140);
    drain_results();
    repeat (200) @(posedge clk);

    $display("covered %0d matrices, %0d results, tolerance 0..65535, limit 1..255",
             sent, results_seen);
    $display("including saturating entries, equal diagonals, pivot ties, stalls");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #300ms;
    $display("timeout after %0t", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/jeig_pkg.sv
design/jeig_mul.sv
design/jeig_div.sv
design/jeig_sqrt.sv
design/jacobi_eigen_3x3_top.sv
verif/jeig_checker.sv
verif/tb_top.sv
